// File: rtl/pctd_pkg.sv
// Shared constants, types and the arctangent table of the pilot CFO tracker.
package pctd_pkg;

  localparam int PHASE_BITS    = 24;
  localparam int PILOT_SAMPLES = 256;
  localparam int SEG_SAMPLES   = 64;
  localparam int NSEG          = PILOT_SAMPLES / SEG_SAMPLES;
  localparam int SEG_LOG2      = $clog2(SEG_SAMPLES);
  localparam int CNT_W         = $clog2(PILOT_SAMPLES + 1);
  localparam int DEN           = SEG_SAMPLES * ((NSEG > 1) ? (NSEG - 1) : 1);
  localparam int DEN_HALF      = DEN / 2;
  localparam int DIV_K         = DEN >> SEG_LOG2;
  localparam int DIV_L         = $clog2(DIV_K);
  localparam int DIV_SH        = 32 + DIV_L;
  localparam logic [32:0] DIV_RECIP =
    33'(((64'd1 << DIV_SH) + 64'(DIV_K) - 64'd1) / 64'(DIV_K));

  localparam int CORDIC_ITERS  = 24;
  localparam int ITER_W        = $clog2(CORDIC_ITERS);
  localparam int CORDIC_GAIN   = 652032874;
  localparam int ROT_FRAC      = 30;
  localparam int VEC_SCALE     = 16;
  localparam int CW            = 39;
  localparam int ZW            = 34;
  localparam int ANG_W         = PHASE_BITS + 1;
  localparam int RND_SH        = 32 - PHASE_BITS;
  localparam int RND_ADD       = (RND_SH > 0) ? (1 << (RND_SH - 1)) : 0;

  localparam int RX_W          = 8;
  localparam int REF_W         = 5;
  localparam int ROT_W         = 5;
  localparam int OUT_W         = 10;
  localparam int OUT_SHIFT     = 3;
  localparam int PREF_W        = 11;
  localparam int VW            = 20;
  localparam int SUM_W         = 32;
  localparam int OFF_W         = 28;
  localparam int NUM_W         = OFF_W + $clog2(PILOT_SAMPLES + 1) + 1;

  localparam logic signed [5:0] ROT_K = 6'sd15;

  typedef struct packed {
    logic signed [RX_W-1:0]  rx_i;
    logic signed [RX_W-1:0]  rx_q;
    logic signed [REF_W-1:0] ref_i;
    logic signed [REF_W-1:0] ref_q;
    logic                    kind;
    logic                    frame_start;
  } item_t;

  typedef struct packed {
    logic                    start;
    logic                    vec;
    logic [PHASE_BITS-1:0]   phase;
    logic signed [VW-1:0]    vx;
    logic signed [VW-1:0]    vy;
  } cordic_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ROT_W-1:0] cos_v;
    logic signed [ROT_W-1:0] sin_v;
    logic signed [ANG_W-1:0] angle;
  } cordic_rsp_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [31:0] atan_lut(input logic [ITER_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/pctd_cordic.sv
// Shared iterative CORDIC: quantised rotor (rotation) and atan2 (vectoring).
module pctd_cordic import pctd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cordic_req_t req_i,
  output cordic_rsp_t rsp_o
);

  localparam logic signed [ZW-1:0] Z_HALF = ZW'(64'h8000_0000);
  localparam logic signed [ZW-1:0] Z_QTR  = ZW'(64'h4000_0000);
  localparam logic signed [ZW-1:0] Z_LIM  = ZW'(64'd1 << (PHASE_BITS - 1));
  localparam logic signed [ZW-1:0] Z_RND  = ZW'(RND_ADD);
  localparam logic signed [CW-1:0] X_GAIN = CW'(CORDIC_GAIN);
  localparam logic signed [ROT_W-1:0] R_ONE = ROT_W'(ROT_K);

  logic                    busy_q, fin_q, done_q;
  logic [ITER_W-1:0]       iter_q;
  logic                    vec_q, neg_q, spec_q;
  logic signed [ROT_W-1:0] spc_c_q, spc_s_q;
  logic signed [CW-1:0]    x_q, y_q;
  logic signed [ZW-1:0]    z_q;
  logic signed [ROT_W-1:0] cos_q, sin_q;
  logic signed [ANG_W-1:0] ang_q;

  logic [31:0]             p32;
  logic signed [ZW-1:0]    a_ext, a_f, z0;
  logic signed [CW-1:0]    vxe, vye, x0, y0;
  logic                    neg_d, spec_d;
  logic signed [ROT_W-1:0] spc_c_d, spc_s_d;

  always_comb begin
    p32     = 32'(req_i.phase) << (32 - PHASE_BITS);
    a_ext   = ZW'($signed(p32));
    a_f     = a_ext;
    neg_d   = 1'b0;
    spec_d  = 1'b0;
    spc_c_d = '0;
    spc_s_d = '0;
    vxe     = CW'($signed(req_i.vx));
    vye     = CW'($signed(req_i.vy));
    x0      = X_GAIN;
    y0      = '0;
    z0      = '0;
    if (a_ext > Z_QTR) begin
      a_f   = a_ext - Z_HALF;
      neg_d = 1'b1;
    end else if (a_ext < -Z_QTR) begin
      a_f   = a_ext + Z_HALF;
      neg_d = 1'b1;
    end
    if (req_i.vec) begin
      neg_d = 1'b0;
      if (vxe == '0 && vye == '0) begin
        spec_d = 1'b1;
      end else if (vxe == '0) begin
        spec_d = 1'b1;
        z0     = (vye > 0) ? Z_QTR : -Z_QTR;
      end else if (vye == '0 && vxe < 0) begin
        spec_d = 1'b1;
        z0     = Z_HALF;
      end else if (vxe < 0) begin
        z0 = (vye >= 0) ? Z_HALF : -Z_HALF;
        x0 = (-vxe) <<< VEC_SCALE;
        y0 = (-vye) <<< VEC_SCALE;
      end else begin
        x0 = vxe <<< VEC_SCALE;
        y0 = vye <<< VEC_SCALE;
      end
    end else begin
      z0 = a_f;
      if (a_f == '0) begin
        spec_d  = 1'b1;
        spc_c_d = R_ONE;
      end else if (a_f == Z_QTR) begin
        spec_d  = 1'b1;
        spc_s_d = R_ONE;
      end else if (a_f == -Z_QTR) begin
        spec_d  = 1'b1;
        spc_s_d = -R_ONE;
      end
    end
  end

  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] atn;
  logic                 sigma;

  assign dx    = y_q >>> iter_q;
  assign dy    = x_q >>> iter_q;
  assign atn   = ZW'(atan_lut(iter_q));
  assign sigma = vec_q ? (y_q < 0) : (z_q >= 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= fin_q;
      if (req_i.start) begin
        iter_q <= '0;
        busy_q <= !spec_d;
        fin_q  <= spec_d;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        busy_q <= (iter_q != ITER_W'(CORDIC_ITERS - 1));
        fin_q  <= (iter_q == ITER_W'(CORDIC_ITERS - 1));
      end else begin
        fin_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      vec_q   <= req_i.vec;
      neg_q   <= neg_d;
      spec_q  <= spec_d;
      spc_c_q <= spc_c_d;
      spc_s_q <= spc_s_d;
      x_q     <= x0;
      y_q     <= y0;
      z_q     <= z0;
    end else if (busy_q) begin
      if (sigma) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - atn;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + atn;
      end
    end
  end

  function automatic logic signed [ROT_W-1:0] trunc_k(input logic signed [CW+4:0] t);
    logic signed [CW+4:0] mag, m;
    mag = (t < 0) ? -t : t;
    m   = mag >>> ROT_FRAC;
    return ROT_W'((t < 0) ? -m : m);
  endfunction

  logic signed [CW+4:0]    t_c, t_s;
  logic signed [ROT_W-1:0] c_f, s_f;
  logic signed [ZW-1:0]    zr;
  logic signed [ANG_W-1:0] ang_f;

  always_comb begin
    t_c = x_q * ROT_K;
    t_s = y_q * ROT_K;
    c_f = spec_q ? spc_c_q : trunc_k(t_c);
    s_f = spec_q ? spc_s_q : trunc_k(t_s);
    if (neg_q) begin
      c_f = -c_f;
      s_f = -s_f;
    end
    zr = (z_q + Z_RND) >>> RND_SH;
    if (zr > Z_LIM) begin
      ang_f = ANG_W'(Z_LIM);
    end else if (zr < -Z_LIM) begin
      ang_f = ANG_W'(-Z_LIM);
    end else begin
      ang_f = ANG_W'(zr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_q) begin
      cos_q <= c_f;
      sin_q <= s_f;
      ang_q <= ang_f;
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.cos_v = cos_q;
  assign rsp_o.sin_v = sin_q;
  assign rsp_o.angle = ang_q;

endmodule

// File: rtl/pctd_div.sv
// Divider by the segment-average denominator: shift by the segment length, then reciprocal multiply.
module pctd_div import pctd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             stg_q, done_q;
  logic [31:0]      m_q;
  logic [NUM_W-1:0] quot_q;
  logic [64:0]      prod;

  assign prod = {33'd0, m_q} * {32'd0, DIV_RECIP};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      stg_q  <= req_i.start;
      done_q <= stg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) m_q <= 32'(req_i.num >> SEG_LOG2);
    if (stg_q) quot_q <= NUM_W'(prod >> DIV_SH);
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// File: rtl/pctd_front.sv
// Input side: takes transfers and queues them in a two-entry buffer for the back end.
module pctd_front import pctd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [RX_W-1:0]  rx_i_i,
  input  logic signed [RX_W-1:0]  rx_q_i,
  input  logic signed [REF_W-1:0] ref_i_i,
  input  logic signed [REF_W-1:0] ref_q_i,
  input  logic                    kind_i,
  input  logic                    frame_start_i,
  output logic                    q_valid_o,
  output item_t                   q_item_o,
  input  logic                    q_pop_i
);

  item_t      buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  item_t      item_d;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = buf_q[rd_ptr_q];

  always_comb begin
    item_d.rx_i        = rx_i_i;
    item_d.rx_q        = rx_q_i;
    item_d.ref_i       = ref_i_i;
    item_d.ref_q       = ref_q_i;
    item_d.kind        = kind_i;
    item_d.frame_start = frame_start_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= item_d;
  end

endmodule

// File: rtl/pctd_back.sv
// Back end: NCO derotation, pilot frequency estimation and output register.
module pctd_back import pctd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  item_t                   q_item_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] out_i_o,
  output logic signed [OUT_W-1:0] out_q_o,
  output logic                    out_kind_o,
  output logic                    step_valid_o
);

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_LOAD = 14'b00000000000010,
    ST_NCO  = 14'b00000000000100,
    ST_MIX  = 14'b00000000001000,
    ST_EST  = 14'b00000000010000,
    ST_PIL  = 14'b00000000100000,
    ST_CX   = 14'b00000001000000,
    ST_VEC  = 14'b00000010000000,
    ST_CNT  = 14'b00000100000000,
    ST_UPD  = 14'b00001000000000,
    ST_DIV1 = 14'b00010000000000,
    ST_DIV2 = 14'b00100000000000,
    ST_FIN  = 14'b01000000000000,
    ST_OUT  = 14'b10000000000000
  } state_e;

  state_e state_q;

  logic [PHASE_BITS-1:0]   nco_phase_q, nco_step_q, pil_rot_q;
  logic signed [SUM_W-1:0] seg_sum_q;
  logic signed [OFF_W-1:0] off_sum_q;
  logic [CNT_W-1:0]        pcnt_q;
  logic                    first_q;
  item_t                   item_q;
  logic signed [OUT_W-1:0] xi_q, xq_q;
  logic signed [ROT_W-1:0] c_q, s_q;
  logic signed [PREF_W-1:0] ra_q, rb_q;
  logic                    out_valid_q, step_vld_q, sv_out_q, kind_out_q;
  logic signed [OUT_W-1:0] oi_q, oq_q;

  cordic_req_t creq;
  cordic_rsp_t crsp;
  div_req_t    dreq;
  div_rsp_t    drsp;

  pctd_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .rsp_o  (crsp)
  );

  pctd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  logic bypass, est_on, seg_nz, seg_end, out_free;
  logic [CNT_W-1:0] seg_idx, pcnt_inc;

  assign bypass   = !item_q.kind && first_q;
  assign seg_idx  = pcnt_q >> SEG_LOG2;
  assign est_on   = (seg_idx < CNT_W'(NSEG));
  assign seg_nz   = (seg_idx != '0);
  assign seg_end  = (pcnt_q[SEG_LOG2-1:0] == {SEG_LOG2{1'b1}});
  assign pcnt_inc = pcnt_q + 1'b1;
  assign out_free = !out_valid_q || out_ready_i;
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;

  logic signed [12:0] m1, m2, m3, m4;
  logic signed [13:0] mi, mq;
  logic signed [9:0]  r1, r2, r3, r4;
  logic signed [20:0] p1, p2, p3, p4;
  logic signed [21:0] cx_full, cy_full;

  assign m1 = item_q.rx_i * c_q;
  assign m2 = item_q.rx_q * s_q;
  assign m3 = item_q.rx_i * s_q;
  assign m4 = item_q.rx_q * c_q;
  assign mi = 14'(m1) - 14'(m2);
  assign mq = 14'(m3) + 14'(m4);

  assign r1 = item_q.ref_i * crsp.cos_v;
  assign r2 = item_q.ref_q * crsp.sin_v;
  assign r3 = item_q.ref_i * crsp.sin_v;
  assign r4 = item_q.ref_q * crsp.cos_v;

  assign p1 = xi_q * ra_q;
  assign p2 = xq_q * rb_q;
  assign p3 = xq_q * ra_q;
  assign p4 = xi_q * rb_q;
  assign cx_full = 22'(p1) + 22'(p2);
  assign cy_full = 22'(p3) - 22'(p4);

  always_comb begin
    creq.start = ((state_q == ST_LOAD) && !bypass)
              || ((state_q == ST_EST) && !item_q.kind && est_on)
              || (state_q == ST_CX);
    creq.vec   = (state_q == ST_CX);
    creq.phase = (state_q == ST_LOAD) ? nco_phase_q : pil_rot_q;
    creq.vx    = VW'(cx_full >>> 2);
    creq.vy    = VW'(cy_full >>> 2);
  end

  logic [OFF_W-1:0] off_abs;
  assign off_abs = (off_sum_q < 0) ? OFF_W'(-off_sum_q) : OFF_W'(off_sum_q);

  always_comb begin
    dreq.start = (state_q == ST_UPD) || ((state_q == ST_DIV1) && drsp.done);
    if (state_q == ST_UPD) begin
      dreq.num = NUM_W'(off_abs) + NUM_W'(DEN_HALF);
    end else begin
      dreq.num = NUM_W'(off_abs) * NUM_W'(PILOT_SAMPLES) + NUM_W'(DEN_HALF);
    end
  end

  logic signed [SUM_W-1:0] sum_new, seg_mean;
  assign sum_new  = seg_sum_q + SUM_W'(crsp.angle);
  assign seg_mean = sum_new >>> SEG_LOG2;

  logic [PHASE_BITS-1:0] div_q;
  assign div_q = PHASE_BITS'(drsp.quot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nco_phase_q <= '0;
      nco_step_q  <= '0;
      pil_rot_q   <= '0;
      seg_sum_q   <= '0;
      off_sum_q   <= '0;
      pcnt_q      <= '0;
      first_q     <= 1'b1;
      step_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != ST_OUT) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            step_vld_q <= 1'b0;
            if (q_item_i.frame_start) begin
              nco_phase_q <= '0;
              nco_step_q  <= '0;
              pil_rot_q   <= '0;
              seg_sum_q   <= '0;
              off_sum_q   <= '0;
              pcnt_q      <= '0;
              first_q     <= 1'b1;
            end
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: state_q <= bypass ? ST_EST : ST_NCO;
        ST_NCO:  if (crsp.done) state_q <= ST_MIX;
        ST_MIX: begin
          nco_phase_q <= nco_phase_q + nco_step_q;
          state_q     <= ST_EST;
        end
        ST_EST: begin
          if (item_q.kind) begin
            pil_rot_q <= '0;
            seg_sum_q <= '0;
            off_sum_q <= '0;
            pcnt_q    <= '0;
            state_q   <= ST_OUT;
          end else if (est_on) begin
            state_q <= ST_PIL;
          end else begin
            state_q <= ST_CNT;
          end
        end
        ST_PIL:  if (crsp.done) state_q <= ST_CX;
        ST_CX:   state_q <= ST_VEC;
        ST_VEC: begin
          if (crsp.done) begin
            if (seg_end) begin
              pil_rot_q <= pil_rot_q + PHASE_BITS'(seg_mean);
              if (seg_nz) off_sum_q <= off_sum_q + OFF_W'(seg_mean);
              seg_sum_q <= '0;
            end else begin
              seg_sum_q <= sum_new;
            end
            state_q <= ST_CNT;
          end
        end
        ST_CNT: begin
          pcnt_q <= pcnt_inc;
          if (pcnt_inc == CNT_W'(PILOT_SAMPLES)) begin
            state_q <= (NSEG >= 2) ? ST_UPD : ST_FIN;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_UPD:  state_q <= ST_DIV1;
        ST_DIV1: begin
          if (drsp.done) begin
            nco_step_q <= (off_sum_q < 0) ? nco_step_q + div_q : nco_step_q - div_q;
            state_q    <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (drsp.done) begin
            nco_phase_q <= (off_sum_q < 0) ? nco_phase_q + div_q : nco_phase_q - div_q;
            state_q     <= ST_FIN;
          end
        end
        ST_FIN: begin
          pil_rot_q  <= '0;
          seg_sum_q  <= '0;
          off_sum_q  <= '0;
          pcnt_q     <= '0;
          first_q    <= 1'b0;
          step_vld_q <= 1'b1;
          state_q    <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) item_q <= q_item_i;
    if (state_q == ST_LOAD && bypass) begin
      xi_q <= OUT_W'(item_q.rx_i);
      xq_q <= OUT_W'(item_q.rx_q);
    end
    if (state_q == ST_NCO && crsp.done) begin
      c_q <= crsp.cos_v;
      s_q <= crsp.sin_v;
    end
    if (state_q == ST_MIX) begin
      xi_q <= OUT_W'(mi >>> OUT_SHIFT);
      xq_q <= OUT_W'(mq >>> OUT_SHIFT);
    end
    if (state_q == ST_PIL && crsp.done) begin
      ra_q <= PREF_W'(r1) - PREF_W'(r2);
      rb_q <= PREF_W'(r3) + PREF_W'(r4);
    end
    if (state_q == ST_OUT && out_free) begin
      oi_q       <= xi_q;
      oq_q       <= xq_q;
      kind_out_q <= item_q.kind;
      sv_out_q   <= step_vld_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_i_o      = oi_q;
  assign out_q_o      = oq_q;
  assign out_kind_o   = kind_out_q;
  assign step_valid_o = sv_out_q;

endmodule

// File: rtl/pilot_cfo_tracking_derotator.sv
// A data sample takes one rotor pass; a pilot takes a rotor pass, a pilot-rotor pass and a
// vector pass, plus two divider runs at block end; first-block pilots skip the rotor pass.
// Samples are handled one at a time; each pass of the shared 24-step CORDIC runs every step,
// but rotors at a multiple of a quarter turn and zero, y-axis or negative-x vectors skip them.
// A two-entry input queue and the output register decouple the sides; in_ready_o drops while the queue is full.
// Reset: rst_ni clears NCO and estimator state asynchronously; frame start clears it per sample.
module pilot_cfo_tracking_derotator import pctd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [RX_W-1:0]  rx_i_i,
  input  logic signed [RX_W-1:0]  rx_q_i,
  input  logic signed [REF_W-1:0] ref_i_i,
  input  logic signed [REF_W-1:0] ref_q_i,
  input  logic                    kind_i,
  input  logic                    frame_start_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] out_i_o,
  output logic signed [OUT_W-1:0] out_q_o,
  output logic                    out_kind_o,
  output logic                    step_valid_o
);

  logic  q_valid, q_pop;
  item_t q_item;

  pctd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_i_i        (rx_i_i),
    .rx_q_i        (rx_q_i),
    .ref_i_i       (ref_i_i),
    .ref_q_i       (ref_q_i),
    .kind_i        (kind_i),
    .frame_start_i (frame_start_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  pctd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_i_o      (out_i_o),
    .out_q_o      (out_q_o),
    .out_kind_o   (out_kind_o),
    .step_valid_o (step_valid_o)
  );

endmodule

// File: bench/pilot_cfo_tracking_derotator_tb.sv
// Self-checking testbench for the pilot CFO tracking derotator, with its own model of the block.
module pilot_cfo_tracking_derotator_tb;
  import pctd_pkg::*;

  typedef struct {
    logic signed [OUT_W-1:0] o_i;
    logic signed [OUT_W-1:0] o_q;
    logic                    o_kind;
    logic                    o_step;
  } sample_out_t;

  localparam logic KIND_PILOT = 1'b0;
  localparam logic KIND_DATA  = 1'b1;
  localparam int   N_ITEMS    = 1250;
  localparam int   CYCLE_LIMIT = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [RX_W-1:0]  rx_i_i = '0;
  logic signed [RX_W-1:0]  rx_q_i = '0;
  logic signed [REF_W-1:0] ref_i_i = '0;
  logic signed [REF_W-1:0] ref_q_i = '0;
  logic kind_i = 1'b0;
  logic frame_start_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] out_i_o;
  logic signed [OUT_W-1:0] out_q_o;
  logic out_kind_o;
  logic step_valid_o;

  pilot_cfo_tracking_derotator u_dut (.*);

  // tracker state
  logic [PHASE_BITS-1:0] nco_ph, nco_inc, est_rot;
  longint seg_sum, off_sum;
  int     n_pilots;
  bit     first_blk;

  item_t       pending_q[$];
  sample_out_t derot_q[$];
  int  errors = 0;
  int  n_outputs = 0;
  longint cycles = 0;

  function automatic longint trunc30(input longint v);
    return v >= 0 ? (v >>> 30) : -((-v) >>> 30);
  endfunction

  function automatic longint round_quot(input longint v, input longint d);
    return v >= 0 ? (v + d / 2) / d : -((-v + d / 2) / d);
  endfunction

  function automatic longint atan_step(input int i);
    return longint'(atan_lut(ITER_W'(i)));
  endfunction

  task automatic rotor_of(input logic [PHASE_BITS-1:0] ph, output longint c, output longint s);
    logic signed [31:0] p32;
    longint a, x, y, dx, dy, q;
    bit neg;
    p32 = {ph, 8'h00};
    a = p32;
    q = longint'(1) <<< 30;
    neg = 0;
    if (a > q) begin a -= 2 * q; neg = 1; end
    else if (a < -q) begin a += 2 * q; neg = 1; end
    if (a == 0) begin c = 15; s = 0; end
    else if (a == q) begin c = 0; s = 15; end
    else if (a == -q) begin c = 0; s = -15; end
    else begin
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (a >= 0) begin x -= dx; y += dy; a -= atan_step(i); end
        else begin x += dx; y -= dy; a += atan_step(i); end
      end
      c = trunc30(15 * x);
      s = trunc30(15 * y);
    end
    if (neg) begin c = -c; s = -s; end
  endtask

  function automatic longint angle_of_vec(input longint xin, input longint yin);
    longint x, y, z, dx, dy, half, lim;
    x = xin;
    y = yin;
    half = longint'(1) <<< 31;
    if (x == 0 && y == 0) z = 0;
    else if (x == 0) z = y > 0 ? half / 2 : -half / 2;
    else if (y == 0 && x < 0) z = half;
    else begin
      z = 0;
      if (x < 0) begin z = y >= 0 ? half : -half; x = -x; y = -y; end
      x *= 65536;
      y *= 65536;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin x += dx; y -= dy; z += atan_step(i); end
        else begin x -= dx; y += dy; z -= atan_step(i); end
      end
    end
    z = (z + RND_ADD) >>> RND_SH;
    lim = longint'(1) <<< (PHASE_BITS - 1);
    if (z > lim) z = lim;
    if (z < -lim) z = -lim;
    return z;
  endfunction

  task automatic clear_est();
    seg_sum = 0;
    est_rot = '0;
    off_sum = 0;
    n_pilots = 0;
  endtask

  task automatic track_pilot(input longint xi, input longint xq, input longint ri,
                             input longint rq);
    longint c, s, a, b, cx, cy, z;
    int seg;
    seg = n_pilots / SEG_SAMPLES;
    if (seg < NSEG) begin
      rotor_of(est_rot, c, s);
      a = ri * c - rq * s;
      b = ri * s + rq * c;
      cx = (xi * a + xq * b) >>> 2;
      cy = (xq * a - xi * b) >>> 2;
      seg_sum += angle_of_vec(cx, cy);
      if (n_pilots % SEG_SAMPLES == SEG_SAMPLES - 1) begin
        z = seg_sum >= 0 ? seg_sum / SEG_SAMPLES
                         : -((-seg_sum + SEG_SAMPLES - 1) / SEG_SAMPLES);
        est_rot = est_rot + PHASE_BITS'(z);
        if (seg != 0) off_sum += z;
        seg_sum = 0;
      end
    end
  endtask

  task automatic derotate(input item_t it, output sample_out_t r);
    longint rxi, rxq, xi, xq, c, s, dlt, jmp;
    rxi = it.rx_i;
    rxq = it.rx_q;
    r.o_step = 1'b0;
    if (it.frame_start) begin
      nco_ph = '0;
      nco_inc = '0;
      clear_est();
      first_blk = 1;
    end
    if (it.kind == KIND_PILOT && first_blk) begin
      xi = rxi;
      xq = rxq;
    end else begin
      rotor_of(nco_ph, c, s);
      xi = (rxi * c - rxq * s) >>> OUT_SHIFT;
      xq = (rxi * s + rxq * c) >>> OUT_SHIFT;
      nco_ph = nco_ph + nco_inc;
    end
    if (it.kind == KIND_DATA) begin
      clear_est();
    end else begin
      track_pilot(xi, xq, it.ref_i, it.ref_q);
      n_pilots++;
      if (n_pilots >= PILOT_SAMPLES) begin
        dlt = 0;
        jmp = 0;
        if (NSEG >= 2) begin
          dlt = -round_quot(off_sum, DEN);
          jmp = -round_quot(off_sum * PILOT_SAMPLES, DEN);
        end
        nco_inc = nco_inc + PHASE_BITS'(dlt);
        nco_ph = nco_ph + PHASE_BITS'(jmp);
        clear_est();
        first_blk = 0;
        r.o_step = 1'b1;
      end
    end
    r.o_i = OUT_W'(xi);
    r.o_q = OUT_W'(xq);
    r.o_kind = it.kind;
  endtask

  function automatic item_t mk(input int ri, input int rq, input int fi, input int fq,
                               input logic k, input logic fs);
    item_t it;
    it.rx_i = RX_W'(ri);
    it.rx_q = RX_W'(rq);
    it.ref_i = REF_W'(fi);
    it.ref_q = REF_W'(fq);
    it.kind = k;
    it.frame_start = fs;
    return it;
  endfunction

  function automatic item_t rnd_item(input logic k, input logic fs);
    return mk($urandom_range(255), $urandom_range(255), int'($urandom_range(30)) - 15,
              int'($urandom_range(30)) - 15, k, fs);
  endfunction

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    nco_ph = '0;
    nco_inc = '0;
    clear_est();
    first_blk = 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  int burst_left = 8, gap_left = 0;
  always @(posedge clk_i) begin
    sample_out_t r;
    logic nv;
    cycles <= cycles + 1;
    if (rst_ni) begin
      nv = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        derotate(pending_q[0], r);
        derot_q.push_back(r);
        void'(pending_q.pop_front());
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          nv = 1'b1;
          rx_i_i <= pending_q[0].rx_i;
          rx_q_i <= pending_q[0].rx_q;
          ref_i_i <= pending_q[0].ref_i;
          ref_q_i <= pending_q[0].ref_q;
          kind_i <= pending_q[0].kind;
          frame_start_i <= pending_q[0].frame_start;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 60);
            gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid_i <= nv;
    end
  end

  // monitor
  int hold_left = 0;
  bit held = 0;
  always @(posedge clk_i) begin
    sample_out_t e;
    logic nr;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_outputs++;
        if (derot_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected output i=%0d q=%0d", $time, out_i_o, out_q_o);
        end else begin
          e = derot_q.pop_front();
          if (out_i_o !== e.o_i || out_q_o !== e.o_q || out_kind_o !== e.o_kind ||
              step_valid_o !== e.o_step) begin
            errors++;
            $display("%0t: mismatch exp i=%0d q=%0d kind=%0b step=%0b got i=%0d q=%0d kind=%0b step=%0b",
                     $time, e.o_i, e.o_q, e.o_kind, e.o_step,
                     out_i_o, out_q_o, out_kind_o, step_valid_o);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else if (!held && n_outputs >= 300) begin
        held = 1;
        hold_left = 800;
        nr = 1'b0;
      end else if (cycles[9:8] == 2'b01) begin
        nr = 1'b1;
      end else begin
        nr = ($urandom_range(3) != 0);
      end
      out_ready_i <= nr;
    end
  end

  initial begin
    int len;
    // data before any pilot, extremes of the rx fields and +-15 on the ref fields
    pending_q.push_back(mk(127, -128, 15, -15, KIND_DATA, 1'b1));
    pending_q.push_back(mk(-128, 127, -15, 15, KIND_DATA, 1'b0));
    pending_q.push_back(mk(-128, -128, -15, -15, KIND_DATA, 1'b0));
    pending_q.push_back(mk(127, 127, 15, 15, KIND_DATA, 1'b0));
    pending_q.push_back(mk(0, 0, 0, 0, KIND_DATA, 1'b0));
    // pilot block cut short by data
    pending_q.push_back(mk(127, 127, 15, 15, KIND_PILOT, 1'b0));
    pending_q.push_back(mk(-128, -128, -15, -15, KIND_PILOT, 1'b0));
    pending_q.push_back(mk(0, 0, 0, 0, KIND_PILOT, 1'b0));
    pending_q.push_back(mk(-128, 0, 15, 0, KIND_PILOT, 1'b0));
    pending_q.push_back(mk(0, 127, 0, -15, KIND_PILOT, 1'b0));
    pending_q.push_back(mk(5, -7, 3, 3, KIND_DATA, 1'b0));
    // frame start on a pilot
    pending_q.push_back(mk(100, -50, 10, -5, KIND_PILOT, 1'b1));
    pending_q.push_back(rnd_item(KIND_DATA, 1'b0));
    while (pending_q.size() < N_ITEMS) begin
      if ($urandom_range(9) < 7) begin
        len = PILOT_SAMPLES;
        case ($urandom_range(5))
          0: len = $urandom_range(1, PILOT_SAMPLES - 1);
          1: len = PILOT_SAMPLES + $urandom_range(1, 70);
          default: ;
        endcase
        for (int i = 0; i < len; i++)
          pending_q.push_back(rnd_item(KIND_PILOT, i == 0 && $urandom_range(3) == 0));
        len = $urandom_range(3, 40);
        for (int i = 0; i < len; i++) pending_q.push_back(rnd_item(KIND_DATA, 1'b0));
      end else begin
        len = $urandom_range(5, 30);
        for (int i = 0; i < len; i++)
          pending_q.push_back(rnd_item(1'($urandom_range(1)), $urandom_range(15) == 0));
      end
    end
    while (pending_q.size() > N_ITEMS) void'(pending_q.pop_back());
    wait (rst_ni);
    wait (pending_q.size() == 0 && !in_valid_i && derot_q.size() == 0);
    repeat (400) @(posedge clk_i);
    if (errors == 0 && derot_q.size() == 0) begin
      $display("** pilot_cfo_tracking_derotator: PASSED **");
    end else begin
      $display("** pilot_cfo_tracking_derotator: FAILED **");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("** pilot_cfo_tracking_derotator: FAILED **");
    $finish;
  end

endmodule
